FILE: design/dqo_pkg.sv
// Shared types, constants and arithmetic helpers for the dual quadrature odometry block.
package dqo_pkg;

  // Counter width; all counters and totals wrap at this width
  localparam int CNT_W = 32;
  // Width of the external numeric fields
  localparam int FIELD_W = 32;

  typedef logic signed [CNT_W-1:0] cnt_t;
  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic [1:0] kind_t;

  // Item kinds
  localparam kind_t KIND_SAMPLE = 2'd0;
  localparam kind_t KIND_TICK   = 2'd1;
  localparam kind_t KIND_LOAD   = 2'd2;

  // Control broadcast to both wheel lanes
  typedef struct packed {
    logic  take;
    kind_t kind;
    logic  primed;
  } lane_ctl_t;

  // What one wheel lane reports for an item
  typedef struct packed {
    cnt_t position;
    cnt_t change;
    logic bad;
  } lane_res_t;

  // (a + b) / 2 truncated toward zero; the sum is kept one bit wider
  function automatic cnt_t half_sum(input cnt_t a, input cnt_t b);
    logic signed [CNT_W:0] s;
    s = {a[CNT_W-1], a} + {b[CNT_W-1], b};
    s = s + {{CNT_W{1'b0}}, s[CNT_W] & s[0]};
    return cnt_t'(s[CNT_W:1]);
  endfunction

endpackage

FILE: design/dual_quadrature_odometry.sv
// Top level of the dual quadrature odometry block: two wheel lanes and a merge stage.
//
//   channel  | direction | tdata                          | tuser
//   ---------+-----------+--------------------------------+----------------
//   s_*      | in        | levels, distance, rotation     | kind
//   m_*      | out       | positions, changes, odometry   | bad_transition
//
// One item is taken per cycle while s_tready is high; each item passes the lane result,
// averaging and output registers in that order before m_tvalid rises for it.
// The two wheel lanes decode in parallel; the merge stage sets the latency.
// rst is synchronous, active high, and clears all counters, totals and distances.
// A stalled output holds the pipeline; bubbles in the stages are absorbed before
// s_tready drops.
module dual_quadrature_odometry (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,   // left_a, left_b, right_a, right_b, distance_value,
                                  // rotation_value, 4 zero bits
  input  logic [1:0]   s_tuser,   // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [287:0] m_tdata,   // left_position, right_position, left_change,
                                  // right_change, mean_change, mean_count, turn_count,
                                  // distance_remaining, rotation_remaining
  output logic         m_tuser    // bad_transition
);

  logic               primed;
  logic               take;
  dqo_pkg::lane_ctl_t ctl;
  dqo_pkg::lane_res_t res_l;
  dqo_pkg::lane_res_t res_r;
  dqo_pkg::field_t    distance_value;
  dqo_pkg::field_t    rotation_value;
  dqo_pkg::cnt_t      left_position;
  dqo_pkg::cnt_t      right_position;
  dqo_pkg::cnt_t      left_change;
  dqo_pkg::cnt_t      right_change;
  dqo_pkg::cnt_t      mean_change;
  dqo_pkg::cnt_t      mean_count;
  dqo_pkg::cnt_t      turn_count;
  dqo_pkg::cnt_t      distance_remaining;
  dqo_pkg::cnt_t      rotation_remaining;

  assign take           = s_tvalid && s_tready;
  assign distance_value = s_tdata[35:4];
  assign rotation_value = s_tdata[67:36];

  assign ctl.take   = take;
  assign ctl.kind   = s_tuser;
  assign ctl.primed = primed;

  // Set primed on the first sample
  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
    end else if (take && s_tuser == dqo_pkg::KIND_SAMPLE) begin
      primed <= 1'b1;
    end
  end

  dqo_lane u_lane_l (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .a   (s_tdata[0]),
    .b   (s_tdata[1]),
    .res (res_l)
  );

  dqo_lane u_lane_r (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .a   (s_tdata[2]),
    .b   (s_tdata[3]),
    .res (res_r)
  );

  dqo_merge u_merge (
    .clk                (clk),
    .rst                (rst),
    .take               (take),
    .ready              (s_tready),
    .kind               (s_tuser),
    .dist_load          (dqo_pkg::cnt_t'(distance_value)),
    .rot_load           (dqo_pkg::cnt_t'(rotation_value)),
    .res_l              (res_l),
    .res_r              (res_r),
    .out_valid          (m_tvalid),
    .out_ready          (m_tready),
    .left_position      (left_position),
    .right_position     (right_position),
    .left_change        (left_change),
    .right_change       (right_change),
    .mean_change        (mean_change),
    .mean_count         (mean_count),
    .turn_count         (turn_count),
    .distance_remaining (distance_remaining),
    .rotation_remaining (rotation_remaining),
    .bad_transition     (m_tuser)
  );

  // Pack results, sign-extended or truncated to the field width
  assign m_tdata = {dqo_pkg::field_t'(rotation_remaining),
                    dqo_pkg::field_t'(distance_remaining),
                    dqo_pkg::field_t'(turn_count),
                    dqo_pkg::field_t'(mean_count),
                    dqo_pkg::field_t'(mean_change),
                    dqo_pkg::field_t'(right_change),
                    dqo_pkg::field_t'(left_change),
                    dqo_pkg::field_t'(right_position),
                    dqo_pkg::field_t'(left_position)};

endmodule

FILE: design/dqo_lane.sv
// One wheel lane: x4 quadrature decode, position counter and tick snapshot.
module dqo_lane (
  input  logic              clk,
  input  logic              rst,
  input  dqo_pkg::lane_ctl_t ctl,
  input  logic              a,
  input  logic              b,
  output dqo_pkg::lane_res_t res
);

  logic          last_a;
  logic          last_b;
  dqo_pkg::cnt_t count;
  dqo_pkg::cnt_t count_next;
  dqo_pkg::cnt_t snapshot;
  logic          a_ch;
  logic          b_ch;
  logic          same;
  logic          is_sample;
  logic          is_tick;
  logic          bad;

  assign is_sample = ctl.kind == dqo_pkg::KIND_SAMPLE;
  assign is_tick   = ctl.kind == dqo_pkg::KIND_TICK;
  assign a_ch      = last_a ^ a;
  assign b_ch      = last_b ^ b;
  assign same      = a ~^ b;

  // Decode one step; a double change counts nothing and flags the sample
  always_comb begin
    count_next = count;
    bad        = 1'b0;
    if (is_sample && ctl.primed) begin
      if (a_ch && b_ch) begin
        bad = 1'b1;
      end else if (a_ch) begin
        count_next = same ? count - dqo_pkg::cnt_t'(1) : count + dqo_pkg::cnt_t'(1);
      end else if (b_ch) begin
        count_next = same ? count + dqo_pkg::cnt_t'(1) : count - dqo_pkg::cnt_t'(1);
      end
    end
  end

  // Report position after the item and, on a tick, the change since the last tick; zero otherwise
  always_comb begin
    res.position = count_next;
    res.change   = is_tick ? count - snapshot : '0;
    res.bad      = bad;
  end

  // Hold levels, count and snapshot; advance on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      last_a   <= 1'b0;
      last_b   <= 1'b0;
      count    <= '0;
      snapshot <= '0;
    end else if (ctl.take) begin
      count <= count_next;
      if (is_sample) begin
        last_a <= a;
        last_b <= b;
      end
      if (is_tick) begin
        snapshot <= count;
      end
    end
  end

endmodule

FILE: design/dqo_merge.sv
// Merge stage: combines both lanes into averages, totals and remaining distances.
module dqo_merge (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  output logic               ready,
  input  dqo_pkg::kind_t     kind,
  input  dqo_pkg::cnt_t      dist_load,
  input  dqo_pkg::cnt_t      rot_load,
  input  dqo_pkg::lane_res_t res_l,
  input  dqo_pkg::lane_res_t res_r,
  output logic               out_valid,
  input  logic               out_ready,
  output dqo_pkg::cnt_t      left_position,
  output dqo_pkg::cnt_t      right_position,
  output dqo_pkg::cnt_t      left_change,
  output dqo_pkg::cnt_t      right_change,
  output dqo_pkg::cnt_t      mean_change,
  output dqo_pkg::cnt_t      mean_count,
  output dqo_pkg::cnt_t      turn_count,
  output dqo_pkg::cnt_t      distance_remaining,
  output dqo_pkg::cnt_t      rotation_remaining,
  output logic               bad_transition
);

  // Stage A: lane results
  logic           va;
  dqo_pkg::kind_t kind_a;
  dqo_pkg::cnt_t  pos_l_a;
  dqo_pkg::cnt_t  pos_r_a;
  dqo_pkg::cnt_t  ch_l_a;
  dqo_pkg::cnt_t  ch_r_a;
  dqo_pkg::cnt_t  dist_a;
  dqo_pkg::cnt_t  rot_a;
  logic           bad_a;

  // Stage B: averages of the changes and updated totals
  logic           vb;
  dqo_pkg::kind_t kind_b;
  dqo_pkg::cnt_t  pos_l_b;
  dqo_pkg::cnt_t  pos_r_b;
  dqo_pkg::cnt_t  ch_l_b;
  dqo_pkg::cnt_t  ch_r_b;
  dqo_pkg::cnt_t  mch_b;
  dqo_pkg::cnt_t  rdiff_b;
  dqo_pkg::cnt_t  lt_b;
  dqo_pkg::cnt_t  rt_b;
  dqo_pkg::cnt_t  dist_b;
  dqo_pkg::cnt_t  rot_b;
  logic           bad_b;

  // Running totals
  dqo_pkg::cnt_t  left_total;
  dqo_pkg::cnt_t  right_total;
  dqo_pkg::cnt_t  left_total_next;
  dqo_pkg::cnt_t  right_total_next;

  // Handshake between the stages and the output
  logic           ready_b;
  logic           ready_c;
  logic           move_ab;
  logic           move_bc;

  assign ready_c = !out_valid || out_ready;
  assign move_bc = vb && ready_c;
  assign ready_b = !vb || ready_c;
  assign move_ab = va && ready_b;
  assign ready   = !va || ready_b;

  // Non-tick items carry zero changes, so totals always add
  assign left_total_next  = left_total + ch_l_a;
  assign right_total_next = right_total + ch_r_a;

  // Stage valid bits and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      va                 <= 1'b0;
      vb                 <= 1'b0;
      out_valid          <= 1'b0;
      left_total         <= '0;
      right_total        <= '0;
      distance_remaining <= '0;
      rotation_remaining <= '0;
    end else begin
      if (take) begin
        va <= 1'b1;
      end else if (move_ab) begin
        va <= 1'b0;
      end
      if (move_ab) begin
        vb          <= 1'b1;
        left_total  <= left_total_next;
        right_total <= right_total_next;
      end else if (move_bc) begin
        vb <= 1'b0;
      end
      if (move_bc) begin
        out_valid <= 1'b1;
        if (kind_b == dqo_pkg::KIND_LOAD) begin
          distance_remaining <= dist_b;
          rotation_remaining <= rot_b;
        end else begin
          distance_remaining <= distance_remaining - mch_b;
          rotation_remaining <= rotation_remaining - rdiff_b;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture lane results on transfer
  always_ff @(posedge clk) begin
    if (take) begin
      kind_a  <= kind;
      pos_l_a <= res_l.position;
      pos_r_a <= res_r.position;
      ch_l_a  <= res_l.change;
      ch_r_a  <= res_r.change;
      dist_a  <= dist_load;
      rot_a   <= rot_load;
      bad_a   <= res_l.bad || res_r.bad;
    end
  end

  // Average the changes and snapshot the totals
  always_ff @(posedge clk) begin
    if (move_ab) begin
      kind_b  <= kind_a;
      pos_l_b <= pos_l_a;
      pos_r_b <= pos_r_a;
      ch_l_b  <= ch_l_a;
      ch_r_b  <= ch_r_a;
      mch_b   <= dqo_pkg::half_sum(ch_l_a, ch_r_a);
      rdiff_b <= ch_r_a - ch_l_a;
      lt_b    <= left_total_next;
      rt_b    <= right_total_next;
      dist_b  <= dist_a;
      rot_b   <= rot_a;
      bad_b   <= bad_a;
    end
  end

  // Fill the output register
  always_ff @(posedge clk) begin
    if (move_bc) begin
      left_position  <= pos_l_b;
      right_position <= pos_r_b;
      left_change    <= ch_l_b;
      right_change   <= ch_r_b;
      mean_change    <= mch_b;
      mean_count     <= dqo_pkg::half_sum(lt_b, rt_b);
      turn_count     <= rt_b - lt_b;
      bad_transition <= bad_b;
    end
  end

`ifndef SYNTHESIS
  a_bad_only_on_sample: assert property (@(posedge clk) disable iff (rst)
    va && kind_a != dqo_pkg::KIND_SAMPLE |-> !bad_a)
    else $error("bad transition flagged on a non-sample item");

  a_quiet_non_tick: assert property (@(posedge clk) disable iff (rst)
    vb && kind_b != dqo_pkg::KIND_TICK |-> mch_b == '0 && rdiff_b == '0)
    else $error("non-tick item carries nonzero changes");

  a_load_sets_remaining: assert property (@(posedge clk) disable iff (rst)
    move_bc && kind_b == dqo_pkg::KIND_LOAD |=>
      distance_remaining == $past(dist_b) && rotation_remaining == $past(rot_b))
    else $error("load did not set remaining distances");

  a_no_lost_item: assert property (@(posedge clk) disable iff (rst)
    va && !move_ab |=> va)
    else $error("stage A item dropped");
`endif

endmodule

FILE: test/dual_quadrature_odometry_tb.sv
// Self-checking testbench for the dual quadrature odometry block.
module dual_quadrature_odometry_tb;

  localparam dqo_pkg::kind_t KIND_UNUSED = 2'd3;
  localparam int    STALL_LIMIT = 2000;   // cycles without any transfer
  localparam int    HOLD_CYCLES = 300;    // long output hold-off
  localparam int    DRAIN_CYCLES = 12;

  // One input item; levels bit0 left_a, bit1 left_b, bit2 right_a, bit3 right_b
  typedef struct {
    dqo_pkg::kind_t  kind;
    logic [3:0]      levels;
    dqo_pkg::field_t dist_val;
    dqo_pkg::field_t rot;
  } odo_item_t;

  // Output word, lowest field in the lowest bits
  typedef struct packed {
    dqo_pkg::field_t rotation_remaining;
    dqo_pkg::field_t distance_remaining;
    dqo_pkg::field_t turn_count;
    dqo_pkg::field_t mean_count;
    dqo_pkg::field_t mean_change;
    dqo_pkg::field_t right_change;
    dqo_pkg::field_t left_change;
    dqo_pkg::field_t right_position;
    dqo_pkg::field_t left_position;
  } odo_word_t;

  typedef struct {
    odo_word_t word;
    logic      bad;
  } odo_result_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [71:0]  s_tdata;   // left_a, left_b, right_a, right_b, distance_value,
                           // rotation_value, 4 zero bits
  logic [1:0]   s_tuser;   // kind
  logic         m_tvalid;
  logic         m_tready;
  logic [287:0] m_tdata;   // left_position, right_position, left_change, right_change,
                           // mean_change, mean_count, turn_count, distance_remaining,
                           // rotation_remaining
  logic         m_tuser;   // bad_transition

  // Predicted odometry state
  logic       primed_q = 1'b0;
  logic [3:0] levels_q = '0;
  dqo_pkg::cnt_t l_cnt = '0, r_cnt = '0, l_snap = '0, r_snap = '0;
  dqo_pkg::cnt_t l_tot = '0, r_tot = '0, fwd_rem = '0, rot_rem = '0;

  odo_result_t odo_expect[$];
  odo_result_t want;
  odo_word_t   got;

  logic       src_gaps;
  logic       sink_gaps;
  logic       hold_req;
  logic [3:0] walk_lv;
  int         mismatches = 0;
  int         n_items = 0;
  int         n_results = 0;
  int         n_ticks = 0;
  int         n_bad = 0;

  dual_quadrature_odometry dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // x4 decode of one wheel; ba is {b, a}; returns 1 on a double change
  function automatic logic wheel_step(input logic [1:0] old_ba, input logic [1:0] new_ba,
                                      output int delta);
    logic ach, bch, same;
    ach = old_ba[0] != new_ba[0];
    bch = old_ba[1] != new_ba[1];
    same = new_ba[0] == new_ba[1];
    delta = 0;
    if (ach && bch) return 1'b1;
    if (ach) delta = same ? -1 : 1;
    else if (bch) delta = same ? 1 : -1;
    return 1'b0;
  endfunction

  // (a + b) / 2 at full precision, truncated toward zero
  function automatic dqo_pkg::cnt_t mean_toward_zero(input dqo_pkg::cnt_t a,
                                                     input dqo_pkg::cnt_t b);
    longint s;
    s = longint'(a) + longint'(b);
    return dqo_pkg::cnt_t'(s / 2);
  endfunction

  // Advance the predicted state by one item and queue its result
  task automatic predict_odometry(input odo_item_t it);
    odo_result_t res;
    dqo_pkg::cnt_t lch, rch, mch;
    int   dl, dr;
    logic bl, br;
    lch = '0;
    rch = '0;
    mch = '0;
    res.bad = 1'b0;
    case (it.kind)
      dqo_pkg::KIND_SAMPLE: begin
        if (primed_q) begin
          bl = wheel_step(levels_q[1:0], it.levels[1:0], dl);
          br = wheel_step(levels_q[3:2], it.levels[3:2], dr);
          l_cnt = l_cnt + dqo_pkg::cnt_t'(dl);
          r_cnt = r_cnt + dqo_pkg::cnt_t'(dr);
          res.bad = bl | br;
        end
        levels_q = it.levels;
        primed_q = 1'b1;
      end
      dqo_pkg::KIND_TICK: begin
        lch = l_cnt - l_snap;
        rch = r_cnt - r_snap;
        mch = mean_toward_zero(lch, rch);
        l_snap = l_cnt;
        r_snap = r_cnt;
        l_tot = l_tot + lch;
        r_tot = r_tot + rch;
        fwd_rem = fwd_rem - mch;
        rot_rem = rot_rem - (rch - lch);
        n_ticks++;
      end
      dqo_pkg::KIND_LOAD: begin
        fwd_rem = it.dist_val;
        rot_rem = it.rot;
      end
      default: ;
    endcase
    res.word.left_position      = l_cnt;
    res.word.right_position     = r_cnt;
    res.word.left_change        = lch;
    res.word.right_change       = rch;
    res.word.mean_change        = mch;
    res.word.mean_count         = mean_toward_zero(l_tot, r_tot);
    res.word.turn_count         = r_tot - l_tot;
    res.word.distance_remaining = fwd_rem;
    res.word.rotation_remaining = rot_rem;
    if (res.bad) n_bad++;
    odo_expect.push_back(res);
  endtask

  // Offer one item from a falling edge and hold it until the transfer
  task automatic send_item(input odo_item_t it);
    if (src_gaps && $urandom_range(99) < 25) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, it.rot, it.dist_val, it.levels};
    s_tuser  <= it.kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_odometry(it);
    n_items++;
    @(negedge clk);
  endtask

  function automatic odo_item_t mk_item(input dqo_pkg::kind_t k, input logic [3:0] lv,
                                        input dqo_pkg::field_t d, input dqo_pkg::field_t r);
    odo_item_t it;
    it.kind = k;
    it.levels = lv;
    it.dist_val = d;
    it.rot = r;
    return it;
  endfunction

  // Move a {b, a} pair one gray step in direction dir (-1, 0, +1)
  function automatic logic [1:0] gray_move(input logic [1:0] ba, input int dir);
    logic [1:0] idx;
    idx = {ba[1], ba[1] ^ ba[0]};
    idx = idx + dir[1:0];
    return {idx[1], idx[1] ^ idx[0]};
  endfunction

  function automatic int pick_dir(input int bias);
    int r;
    r = $urandom_range(9);
    if (r < 6) return bias;
    if (r < 8) return 0;
    return -bias;
  endfunction

  // Priming, both turning directions, double changes, loads at the extremes
  task automatic test_directed();
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    send_item(mk_item(dqo_pkg::KIND_TICK, 4'b0000, $urandom, $urandom));  // tick on reset counts
    send_item(mk_item(dqo_pkg::KIND_LOAD, 4'b1111, 32'h7FFF_FFFF, 32'h8000_0000));
    send_item(mk_item(dqo_pkg::KIND_TICK, 4'b0000, $urandom, $urandom));
    send_item(mk_item(dqo_pkg::KIND_SAMPLE, 4'b1111, $urandom, $urandom)); // primes only
    send_item(mk_item(dqo_pkg::KIND_SAMPLE, 4'b0110, $urandom, $urandom)); // left up, right down
    send_item(mk_item(dqo_pkg::KIND_SAMPLE, 4'b0000, $urandom, $urandom));
    send_item(mk_item(dqo_pkg::KIND_SAMPLE, 4'b0111, $urandom, $urandom)); // left double
    send_item(mk_item(dqo_pkg::KIND_SAMPLE, 4'b1011, $urandom, $urandom)); // right double
    send_item(mk_item(dqo_pkg::KIND_SAMPLE, 4'b0100, $urandom, $urandom)); // both double
    send_item(mk_item(dqo_pkg::KIND_TICK, 4'b1111, $urandom, $urandom));
    send_item(mk_item(dqo_pkg::KIND_SAMPLE, 4'b0110, $urandom, $urandom)); // left down
    send_item(mk_item(dqo_pkg::KIND_TICK, 4'b1010, $urandom, $urandom));   // odd negative mean
    send_item(mk_item(KIND_UNUSED, 4'b1001, $urandom, $urandom));
    send_item(mk_item(dqo_pkg::KIND_SAMPLE, 4'b0110, $urandom, $urandom)); // no change
    send_item(mk_item(dqo_pkg::KIND_LOAD, 4'b0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_item(mk_item(dqo_pkg::KIND_SAMPLE, 4'b1111, $urandom, $urandom));
    send_item(mk_item(dqo_pkg::KIND_TICK, 4'b0000, $urandom, $urandom));   // rotation wraps
    send_item(mk_item(dqo_pkg::KIND_SAMPLE, 4'b0101, $urandom, $urandom));
    send_item(mk_item(dqo_pkg::KIND_SAMPLE, 4'b0100, $urandom, $urandom));
    send_item(mk_item(dqo_pkg::KIND_TICK, 4'b1111, $urandom, $urandom));   // distance wraps
    send_item(mk_item(dqo_pkg::KIND_LOAD, 4'b0101, 32'h0000_0000, 32'hFFFF_FFFF));
    send_item(mk_item(dqo_pkg::KIND_LOAD, 4'b1010, 32'hFFFF_FFFF, 32'h0000_0000));
    send_item(mk_item(KIND_UNUSED, 4'b0000, 32'h0, 32'h0));
    walk_lv = 4'b0100;
  endtask

  // Mostly legal encoder motion with random ticks, loads and unused kinds, some pin noise
  task automatic test_random_walk(input int count, input logic gaps);
    odo_item_t it;
    int roll;
    int bias_l, bias_r;
    src_gaps = gaps;
    sink_gaps = gaps;
    bias_l = $urandom_range(1) ? 1 : -1;
    bias_r = $urandom_range(1) ? 1 : -1;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if ($urandom_range(99) == 0) bias_l = -bias_l;
      if ($urandom_range(99) == 0) bias_r = -bias_r;
      if (roll < 8) begin
        it = mk_item(dqo_pkg::KIND_TICK, 4'($urandom_range(15)), $urandom, $urandom);
      end else if (roll < 10) begin
        it = mk_item(dqo_pkg::KIND_LOAD, 4'($urandom_range(15)), $urandom, $urandom);
      end else if (roll < 11) begin
        it = mk_item(KIND_UNUSED, 4'($urandom_range(15)), $urandom, $urandom);
      end else begin
        if (roll < 15) begin
          walk_lv = 4'($urandom_range(15));
        end else begin
          walk_lv[1:0] = gray_move(walk_lv[1:0], pick_dir(bias_l));
          walk_lv[3:2] = gray_move(walk_lv[3:2], pick_dir(bias_r));
        end
        it = mk_item(dqo_pkg::KIND_SAMPLE, walk_lv, $urandom, $urandom);
      end
      send_item(it);
    end
  endtask

  // Hold the output off for a long stretch while items keep coming
  task automatic test_backpressure();
    odo_item_t it;
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    hold_req = 1'b1;
    for (int n = 0; n < 48; n++) begin
      walk_lv[1:0] = gray_move(walk_lv[1:0], 1);
      walk_lv[3:2] = gray_move(walk_lv[3:2], -1);
      if (n % 6 == 5) it = mk_item(dqo_pkg::KIND_TICK, walk_lv, $urandom, $urandom);
      else it = mk_item(dqo_pkg::KIND_SAMPLE, walk_lv, $urandom, $urandom);
      send_item(it);
    end
  endtask

  // Output ready: random stalls, or one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        m_tready <= 1'b1;
      end else begin
        m_tready <= !(sink_gaps && $urandom_range(99) < 20);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp,
                             input logic [31:0] act);
    if (act !== exp) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, exp, act);
      mismatches++;
    end
  endtask

  // Compare each output transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (odo_expect.size() == 0) begin
        $error("output transfer with no prediction pending");
        mismatches++;
      end else begin
        want = odo_expect.pop_front();
        got = odo_word_t'(m_tdata);
        check_field("left_position", want.word.left_position, got.left_position);
        check_field("right_position", want.word.right_position, got.right_position);
        check_field("left_change", want.word.left_change, got.left_change);
        check_field("right_change", want.word.right_change, got.right_change);
        check_field("mean_change", want.word.mean_change, got.mean_change);
        check_field("mean_count", want.word.mean_count, got.mean_count);
        check_field("turn_count", want.word.turn_count, got.turn_count);
        check_field("distance_remaining", want.word.distance_remaining,
                    got.distance_remaining);
        check_field("rotation_remaining", want.word.rotation_remaining,
                    got.rotation_remaining);
        check_field("bad_transition", {31'b0, want.bad}, {31'b0, m_tuser});
      end
    end
  end

  // Abort when no transfer happens on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("dual_quadrature_odometry regression: fail");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = dqo_pkg::KIND_SAMPLE;
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    hold_req = 1'b0;
    walk_lv = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_walk(700, 1'b1);
    test_random_walk(300, 1'b0);
    test_backpressure();
    test_random_walk(560, 1'b1);

    // Drain outstanding results, then let the pipeline settle
    s_tvalid <= 1'b0;
    while (odo_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d items sent, %0d ticks, %0d results checked, %0d bad transitions",
             n_items, n_ticks, n_results, n_bad);
    $display("summary: gray-code walks with pin noise, extreme loads, long output hold-off");
    if (mismatches == 0) begin
      $display("dual_quadrature_odometry regression: pass");
    end else begin
      $display("dual_quadrature_odometry regression: fail");
    end
    $finish;
  end

endmodule
